// ===== hdl/alias_table_builder_2d_assert.svh =====
// assertion macros for the alias table builder
// used by alias_table_builder_2d; expects clk and arst_n in scope
`ifndef ALIAS_TABLE_BUILDER_2D_ASSERT_SVH
`define ALIAS_TABLE_BUILDER_2D_ASSERT_SVH

// condition holds in the same cycle
`define ATB_ASSERT_NOW(label, cond, consq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (consq)) \
		else $error(msg);

// condition implies the consequence in the next cycle
`define ATB_ASSERT_NEXT(label, cond, consq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (consq)) \
		else $error(msg);

`endif

// ===== hdl/atb_pkg.sv =====
// shared constants and helpers for the alias table builder
// no dependencies
package atb_pkg;
	localparam int ROW_W   = 8;
	localparam int COL_W   = 8;
	localparam int DIM_W   = 9;
	localparam int WGT_W   = 16;
	localparam int SUM_W   = 24;
	localparam int GRID_W  = 32;
	localparam int VAL_W   = 40;
	localparam int PROD_W  = SUM_W + DIM_W;
	localparam int ENT_W   = ROW_W + VAL_W;
	localparam logic [DIM_W-1:0] MAX_DIM = 9'd256;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ROW  = 2'd1;
	localparam logic [1:0] OP_COL  = 2'd2;

	localparam logic REG_ROW_LENGTH = 1'b0;
	localparam logic REG_ROW_COUNT  = 1'b1;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_PAIR = 2'd0;
	localparam mode_t MODE_G    = 2'd1;
	localparam mode_t MODE_L    = 2'd2;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = 9'd1;
		else if (v > MAX_DIM)
			r = MAX_DIM;
		return r;
	endfunction
endpackage

// ===== hdl/alias_table_builder_2d.sv =====
// alias table builder top level: weight store, row and column alias tables
// depends on atb_pkg and alias_table_builder_2d_assert.svh
// read results are registered and appear in the next cycle, one read transfer per cycle while not busy.
// the build after the last load walks each row of weights in a sum pass,
// a scale and split pass and a pairing and drain pass, then runs a column
// pass over the row sums; busy stays high throughout.
// reset clears control state and totals; memories hold no reset value.
// results are strobed by done for one cycle and cannot be stalled.
`include "alias_table_builder_2d_assert.svh"

module alias_table_builder_2d import atb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic [ROW_W-1:0]     row,
	input  logic [COL_W-1:0]     column,
	input  logic [WGT_W-1:0]     weight,
	input  logic                 last,
	output logic                 done,
	output logic [ROW_W-1:0]     alias_index,
	output logic [31:0]          threshold,
	output logic [31:0]          weight_total,
	output logic [VAL_W-1:0]     threshold_total,
	output logic                 table_valid
);
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SUM_RD   = 4'd1;
	localparam logic [3:0] ST_SUM_ACC  = 4'd2;
	localparam logic [3:0] ST_SPL_RD   = 4'd3;
	localparam logic [3:0] ST_SPL_MUL  = 4'd4;
	localparam logic [3:0] ST_SPL_PUSH = 4'd5;
	localparam logic [3:0] ST_TBL_RD   = 4'd6;
	localparam logic [3:0] ST_TBL_WR   = 4'd7;

	logic [WGT_W-1:0]  weight_mem [0:65535];
	logic [ROW_W-1:0]  row_alias_mem [0:65535];
	logic [31:0]       row_thr_mem [0:65535];
	logic [ENT_W-1:0]  col_mem [0:255];
	logic [SUM_W-1:0]  sums_mem [0:255];
	logic [ENT_W-1:0]  lq_mem [0:255];
	logic [ENT_W-1:0]  gq_mem [0:255];

	logic [DIM_W-1:0]  row_length_q, row_count_q;
	logic [DIM_W-1:0]  len_q, rows_q, built_len_q, built_rows_q;
	logic [3:0]        state_q;
	logic              col_phase_q, built_q;
	logic [ROW_W-1:0]  cur_row_q, idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [GRID_W-1:0] total_q, grid_q;
	logic [VAL_W-1:0]  cts_q;
	logic [PROD_W-1:0] prod_q;
	mode_t             mode_q;
	logic [7:0]        lq_head_q, gq_head_q;
	logic [8:0]        lq_cnt_q, gq_cnt_q;

	logic [WGT_W-1:0]  wgt_rd;
	logic [SUM_W-1:0]  sums_rd;
	logic [ENT_W-1:0]  lq_rd, gq_rd, col_rd;
	logic [ROW_W-1:0]  row_alias_rd;
	logic [31:0]       row_thr_rd;

	logic              in_xfer, rd_xfer, rd_row_s1, rd_in_s1, flag_s1;

	logic              lq_push, gq_push, lq_pop, gq_pop, tbl_we;
	logic [ENT_W-1:0]  push_data;
	logic [ROW_W-1:0]  tbl_idx, tbl_alias;
	logic [VAL_W-1:0]  tbl_thr, new_val;
	logic [7:0]        sums_addr;
	logic              idx_last;

	assign busy     = (state_q != ST_IDLE);
	assign in_xfer  = start && !busy;
	assign rd_xfer  = in_xfer && (operation == OP_ROW || operation == OP_COL);
	assign idx_last = ({1'b0, idx_q} == ((col_phase_q ? rows_q : len_q) - 9'd1));
	assign new_val  = gq_rd[VAL_W-1:0] - {8'd0, total_q} + lq_rd[VAL_W-1:0];

	// table writes and queue traffic
	always_comb begin
		lq_push   = 1'b0;
		gq_push   = 1'b0;
		lq_pop    = 1'b0;
		gq_pop    = 1'b0;
		tbl_we    = 1'b0;
		push_data = {idx_q, {(VAL_W-PROD_W){1'b0}}, prod_q};
		tbl_idx   = lq_rd[ENT_W-1:VAL_W];
		tbl_alias = gq_rd[ENT_W-1:VAL_W];
		tbl_thr   = lq_rd[VAL_W-1:0];
		if (state_q == ST_SPL_PUSH) begin
			if ({{(VAL_W-PROD_W){1'b0}}, prod_q} >= {8'd0, total_q})
				gq_push = 1'b1;
			else
				lq_push = 1'b1;
		end else if (state_q == ST_TBL_WR) begin
			tbl_we = 1'b1;
			unique case (mode_q)
				MODE_PAIR: begin
					lq_pop    = 1'b1;
					gq_pop    = 1'b1;
					push_data = {gq_rd[ENT_W-1:VAL_W], new_val};
					if (new_val < {8'd0, total_q})
						lq_push = 1'b1;
					else
						gq_push = 1'b1;
				end
				MODE_G: begin
					gq_pop    = 1'b1;
					tbl_idx   = gq_rd[ENT_W-1:VAL_W];
					tbl_alias = gq_rd[ENT_W-1:VAL_W];
					tbl_thr   = gq_rd[VAL_W-1:0];
				end
				default: begin
					lq_pop    = 1'b1;
					tbl_alias = lq_rd[ENT_W-1:VAL_W];
				end
			endcase
		end
	end

	assign sums_addr = busy ? idx_q : row;

	// memories
	always_ff @(posedge clk) begin
		if (in_xfer && operation == OP_LOAD)
			weight_mem[{row, column}] <= weight;
		wgt_rd <= weight_mem[{cur_row_q, idx_q}];
		if (tbl_we && !col_phase_q) begin
			row_alias_mem[{cur_row_q, tbl_idx}] <= tbl_alias;
			row_thr_mem[{cur_row_q, tbl_idx}]   <= tbl_thr[31:0];
		end
		row_alias_rd <= row_alias_mem[{row, column}];
		row_thr_rd   <= row_thr_mem[{row, column}];
		if (tbl_we && col_phase_q)
			col_mem[tbl_idx] <= {tbl_alias, tbl_thr};
		col_rd <= col_mem[row];
		if (state_q == ST_TBL_RD && !col_phase_q && lq_cnt_q == '0 && gq_cnt_q == '0)
			sums_mem[cur_row_q] <= total_q[SUM_W-1:0];
		sums_rd <= sums_mem[sums_addr];
		if (lq_push)
			lq_mem[lq_head_q + lq_cnt_q[7:0]] <= push_data;
		if (gq_push)
			gq_mem[gq_head_q + gq_cnt_q[7:0]] <= push_data;
		lq_rd <= lq_mem[lq_head_q];
		gq_rd <= gq_mem[gq_head_q];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= 9'd256;
			row_count_q  <= 9'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_LENGTH: row_length_q <= cfg_data;
				default:        row_count_q  <= cfg_data;
			endcase
		end
	end

	// build sequencer; queues are always empty between tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_phase_q  <= 1'b0;
			built_q      <= 1'b0;
			len_q        <= 9'd1;
			rows_q       <= 9'd1;
			built_len_q  <= '0;
			built_rows_q <= '0;
			cur_row_q    <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			total_q      <= '0;
			grid_q       <= '0;
			cts_q        <= '0;
			prod_q       <= '0;
			mode_q       <= MODE_PAIR;
			lq_head_q    <= '0;
			gq_head_q    <= '0;
			lq_cnt_q     <= '0;
			gq_cnt_q     <= '0;
		end else begin
			lq_head_q <= lq_head_q + {7'd0, lq_pop};
			gq_head_q <= gq_head_q + {7'd0, gq_pop};
			lq_cnt_q  <= lq_cnt_q + {8'd0, lq_push} - {8'd0, lq_pop};
			gq_cnt_q  <= gq_cnt_q + {8'd0, gq_push} - {8'd0, gq_pop};
			if (tbl_we && col_phase_q)
				cts_q <= cts_q + tbl_thr;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && operation == OP_LOAD) begin
						built_q <= 1'b0;
						if (last) begin
							len_q        <= clamp_dim(row_length_q);
							rows_q       <= clamp_dim(row_count_q);
							built_len_q  <= clamp_dim(row_length_q);
							built_rows_q <= clamp_dim(row_count_q);
							col_phase_q  <= 1'b0;
							cur_row_q    <= '0;
							idx_q        <= '0;
							sum_q        <= '0;
							grid_q       <= '0;
							state_q      <= ST_SUM_RD;
						end
					end
				end
				ST_SUM_RD: state_q <= ST_SUM_ACC;
				ST_SUM_ACC: begin
					sum_q <= sum_q + {8'd0, wgt_rd};
					if (idx_last) begin
						idx_q   <= '0;
						total_q <= {8'd0, sum_q + {8'd0, wgt_rd}};
						state_q <= ST_SPL_RD;
					end else begin
						idx_q   <= idx_q + 8'd1;
						state_q <= ST_SUM_RD;
					end
				end
				ST_SPL_RD: state_q <= ST_SPL_MUL;
				ST_SPL_MUL: begin
					if (col_phase_q)
						prod_q <= PROD_W'(sums_rd) * PROD_W'(rows_q);
					else
						prod_q <= PROD_W'(wgt_rd) * PROD_W'(len_q);
					state_q <= ST_SPL_PUSH;
				end
				ST_SPL_PUSH: begin
					idx_q <= idx_q + 8'd1;
					if (idx_last)
						state_q <= ST_TBL_RD;
					else
						state_q <= ST_SPL_RD;
				end
				ST_TBL_RD: begin
					priority if (lq_cnt_q != '0 && gq_cnt_q != '0) begin
						mode_q  <= MODE_PAIR;
						state_q <= ST_TBL_WR;
					end else if (gq_cnt_q != '0) begin
						mode_q  <= MODE_G;
						state_q <= ST_TBL_WR;
					end else if (lq_cnt_q != '0) begin
						mode_q  <= MODE_L;
						state_q <= ST_TBL_WR;
					end else if (col_phase_q) begin
						built_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						// row finished: fold its sum into the grid total
						grid_q <= grid_q + total_q;
						idx_q  <= '0;
						sum_q  <= '0;
						if ({1'b0, cur_row_q} == rows_q - 9'd1) begin
							col_phase_q <= 1'b1;
							total_q     <= grid_q + total_q;
							cts_q       <= '0;
							state_q     <= ST_SPL_RD;
						end else begin
							cur_row_q <= cur_row_q + 8'd1;
							state_q   <= ST_SUM_RD;
						end
					end
				end
				ST_TBL_WR: state_q <= ST_TBL_RD;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done      <= 1'b0;
			rd_row_s1 <= 1'b0;
			rd_in_s1  <= 1'b0;
			flag_s1   <= 1'b0;
		end else begin
			done      <= rd_xfer;
			rd_row_s1 <= (operation == OP_ROW);
			flag_s1   <= built_q;
			if (operation == OP_ROW)
				rd_in_s1 <= ({1'b0, row} < built_rows_q) && ({1'b0, column} < built_len_q);
			else
				rd_in_s1 <= ({1'b0, row} < built_rows_q);
		end
	end

	always_comb begin
		table_valid = flag_s1;
		if (rd_row_s1) begin
			alias_index     = rd_in_s1 ? row_alias_rd : '0;
			threshold       = rd_in_s1 ? row_thr_rd : '0;
			weight_total    = rd_in_s1 ? {8'd0, sums_rd} : '0;
			threshold_total = '0;
		end else begin
			alias_index     = rd_in_s1 ? col_rd[ENT_W-1:VAL_W] : '0;
			threshold       = rd_in_s1 ? col_rd[31:0] : '0;
			weight_total    = grid_q;
			threshold_total = cts_q;
		end
	end

	`ATB_ASSERT_NEXT(a_read_strobe, rd_xfer, done, "read transfer gave no result")
	`ATB_ASSERT_NEXT(a_last_starts, in_xfer && operation == OP_LOAD && last, busy && !built_q, "last load did not start a build")
	`ATB_ASSERT_NOW(a_queue_bound, busy, (lq_cnt_q + gq_cnt_q) <= 9'd256, "alias queues overflow")
endmodule
